// ===== hw/rtl/qsle_pkg.sv =====
// shared constants and payload types for the quicksort engine
`default_nettype none

package qsle_pkg;

    localparam int DEPTH       = 64;
    localparam int STACK_DEPTH = DEPTH;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
        logic                     overflow;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } t_range;

endpackage

`default_nettype wire

// ===== hw/rtl/quicksort_lomuto_engine_top.sv =====
// quicksort engine: load a set, sort it in place with lomuto partitioning, stream it out
//
//  channel   direction   handshake                 payload
//  input     in          i_in_valid / o_in_ready   i_in_data  (t_in_item)
//  output    out         o_out_valid / i_out_ready o_out_data (t_out_item)
//
// loading takes one cycle per item; an item flagged last starts the sort
// the sort runs on one compare unit and one store with two read ports and one write
// port: each element is read and compared, and one not above the pivot is also swapped
// forward, while each partitioned range takes a pop, a pivot read and pushes of its two parts
// results are read out of the store one at a time and held while the output side stalls
// the input is not ready from the last item until the final result is in the output
// register; the output register lets the next set start loading while it waits
// synchronous active-low reset clears control state only; no clearing pass
`default_nettype none

module quicksort_lomuto_engine_top
    import qsle_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_POP,
        S_POP_RD,
        S_PIV,
        S_READ,
        S_CMP,
        S_WR2,
        S_PUSH_R,
        S_PUSH_L,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic                     r_ovf;
    logic [SP_W-1:0]          r_sp;
    logic [IDX_W-1:0]         r_lo;
    logic [IDX_W-1:0]         r_hi;
    logic [IDX_W-1:0]         r_j;
    logic [IDX_W-1:0]         r_fill;
    logic [CNT_W-1:0]         r_k;
    logic signed [DATA_W-1:0] r_pivot;
    logic                     r_out_valid;
    t_out_item                r_out_data;

    // element store, two registered read ports
    logic signed [DATA_W-1:0] r_store [DEPTH];
    logic signed [DATA_W-1:0] r_rda;
    logic signed [DATA_W-1:0] r_rdb;
    logic                     store_we;
    logic [IDX_W-1:0]         store_waddr;
    logic signed [DATA_W-1:0] store_wdata;
    logic [IDX_W-1:0]         rd_addr_a;

    // range stack
    t_range                   r_stack [STACK_DEPTH];
    t_range                   r_stk_rd;
    logic                     stk_we;
    logic [STK_IDX_W-1:0]     stk_waddr;
    t_range                   stk_wdata;
    logic [STK_IDX_W-1:0]     stk_raddr;

    logic                     in_accept;
    logic                     out_free;
    logic                     out_load;
    logic                     le_pivot;
    logic [IDX_W:0]           p_plus;
    logic                     sp_room;
    logic                     push_r_ok;
    logic                     push_l_ok;
    logic                     emit_last;
    logic [CNT_W-1:0]         count_m1;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign out_load  = (r_state == S_EMIT_LD) && out_free;
    assign le_pivot  = r_rda <= r_pivot;
    assign p_plus    = {1'b0, r_fill} + 1'b1;
    assign sp_room   = r_sp < SP_W'(STACK_DEPTH);
    assign push_r_ok = (p_plus < {1'b0, r_hi}) && sp_room;
    // lo < p - 1
    assign push_l_ok = (({1'b0, r_lo} + 1'b1) < {1'b0, r_fill}) && sp_room;
    assign count_m1  = r_count - 1'b1;
    assign emit_last = r_k == count_m1;

    always_comb begin
        store_we    = 1'b0;
        store_waddr = r_fill;
        store_wdata = r_rda;
        rd_addr_a   = r_j;
        stk_we      = 1'b0;
        stk_waddr   = r_sp[STK_IDX_W-1:0];
        stk_wdata   = '{lo: p_plus[IDX_W-1:0], hi: r_hi};
        stk_raddr   = STK_IDX_W'(r_sp - 1'b1);
        unique case (r_state)
            S_LOAD: begin
                store_we    = in_accept && (r_count < CNT_W'(DEPTH));
                store_waddr = r_count[IDX_W-1:0];
                store_wdata = i_in_data.value;
            end
            S_INIT: begin
                stk_we    = r_count >= CNT_W'(2);
                stk_waddr = '0;
                stk_wdata = '{lo: '0, hi: count_m1[IDX_W-1:0]};
            end
            S_POP_RD: begin
                rd_addr_a = r_stk_rd.hi;
            end
            S_CMP: begin
                store_we    = le_pivot;
                store_waddr = r_fill;
                store_wdata = r_rda;
            end
            S_WR2: begin
                store_we    = 1'b1;
                store_waddr = r_j;
                store_wdata = r_rdb;
            end
            S_PUSH_R: begin
                stk_we = push_r_ok;
            end
            S_PUSH_L: begin
                stk_we    = push_l_ok;
                stk_wdata = '{lo: r_lo, hi: r_fill - 1'b1};
            end
            S_EMIT_RD, S_EMIT_LD: begin
                rd_addr_a = r_k[IDX_W-1:0];
            end
            default: begin
                rd_addr_a = r_j;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_waddr] <= store_wdata;
        end
        r_rda <= r_store[rd_addr_a];
        r_rdb <= r_store[r_fill];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= r_stack[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_accept) begin
                        if (r_count < CNT_W'(DEPTH)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_data.last) begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_k <= '0;
                    if (r_count < CNT_W'(2)) begin
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_sp    <= SP_W'(1);
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_k     <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_sp    <= r_sp - 1'b1;
                        r_state <= S_POP_RD;
                    end
                end
                S_POP_RD: begin
                    r_lo    <= r_stk_rd.lo;
                    r_hi    <= r_stk_rd.hi;
                    r_state <= S_PIV;
                end
                S_PIV: begin
                    if (r_lo >= r_hi) begin
                        r_state <= S_POP;
                    end else begin
                        r_pivot <= r_rda;
                        r_j     <= r_lo;
                        r_fill  <= r_lo;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // the pivot itself always compares as less or equal, closing the scan
                    if (le_pivot) begin
                        r_state <= S_WR2;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_WR2: begin
                    if (r_j == r_hi) begin
                        r_state <= S_PUSH_R;
                    end else begin
                        r_fill  <= r_fill + 1'b1;
                        r_j     <= r_j + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_PUSH_R: begin
                    if (push_r_ok) begin
                        r_sp <= r_sp + 1'b1;
                    end
                    r_state <= S_PUSH_L;
                end
                S_PUSH_L: begin
                    if (push_l_ok) begin
                        r_sp <= r_sp + 1'b1;
                    end
                    r_state <= S_POP;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (out_free) begin
                        r_out_data.sorted_value <= r_rda;
                        r_out_data.end_of_set   <= emit_last;
                        r_out_data.overflow     <= r_ovf;
                        if (emit_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_sp    <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_ready  = r_state == S_LOAD;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== hw/rtl/qsle_checker.sv =====
// port-level checks for the quicksort engine and their bind
`default_nettype none

module qsle_checker
    import qsle_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");

    // a set is still being emitted, so loading must be closed
    a_no_load_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.end_of_set |-> !o_in_ready)
        else $error("input open while a set is being emitted");

    // an item that does not end the set keeps loading open
    a_keep_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.last |=> o_in_ready)
        else $error("input closed after a non-final item");

    // the final item closes loading for the sort
    a_close_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last |=> !o_in_ready)
        else $error("input still open after the final item");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("outputs not idle after reset");

endmodule

bind quicksort_lomuto_engine_top qsle_checker u_qsle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
